@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the whitelist table RTL.
// Needs a clock i_clk and an active low reset i_rst_n in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PDWT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PDWT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ hw/rtl/pdwt_pkg.sv @@
// Package for the paired-device whitelist table: sizes, codes, payload types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdwt_pkg;

    localparam int ENTRIES       = 8;
    localparam int SLOT_ID_BYTES = 8;
    localparam int IDX_W         = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    typedef enum logic [2:0] {
        K_ADD       = 3'd0,
        K_REMOVE    = 3'd1,
        K_SYNC_MARK = 3'd2,
        K_SYNC_FIN  = 3'd3,
        K_CLEAR     = 3'd4,
        K_LOOKUP    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_FULL    = 2'd1,
        ST_NOMATCH = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINAL
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot_len;
        logic [63:0] slot_id;
        logic [47:0] mac;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [15:0] device_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic        bond_drop;
        logic [15:0] dropped_device;
        logic [63:0] found_key_hi;
        logic [63:0] found_key_lo;
        logic        last;
    } t_out;

    typedef struct packed {
        logic        valid;
        logic        mark;
        logic [3:0]  slot_len;
        logic [63:0] slot_id;
        logic [47:0] mac;
        logic [63:0] key_hi;
        logic [63:0] key_lo;
        logic [15:0] device;
    } t_rec;

    // Keeps the first len bytes (counted from the top) of a slot id.
    function automatic logic [63:0] slot_mask(input logic [3:0] len);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            m[63 - 8 * b -: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/paired_device_whitelist_table.sv @@
// Top level of the paired-device whitelist table: ring of record cells
// plus walk controller. Depends on pdwt_pkg, pdwt_cell and pdwt_ctrl.
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+------------------------
//   input   | i_in_valid  | o_in_ready   | i_in  (pdwt_pkg::t_in)
//   output  | o_out_valid | i_out_ready  | o_out (pdwt_pkg::t_out)
//
// One item at a time: an item is accepted, then walks the ring, one cell per
// cycle while no drop result waits on a stalled output (the ring rotating
// once), and then gives its closing result.
// A sync finish that drops bonds has no closing result.
// Sync finish gives one result per dropped bond; a stalled output holds
// the walk at the current cell. Reset empties the table at once (valid
// and keep marks cleared in every cell), no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module paired_device_whitelist_table (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pdwt_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output pdwt_pkg::t_out      o_out
);

    // cell k holds entry k at rest; on shift cell k takes cell k+1 and the
    // last cell takes the controller's updated head record
    pdwt_pkg::t_rec               cell_q [pdwt_pkg::ENTRIES];
    pdwt_pkg::t_rec               cell_d [pdwt_pkg::ENTRIES];
    pdwt_pkg::t_rec               tail_rec;
    logic                         shift;
    logic [pdwt_pkg::ENTRIES-1:0] drop_mask;

    for (genvar k = 0; k < pdwt_pkg::ENTRIES; k++) begin : g_cell
        if (k == pdwt_pkg::ENTRIES - 1) begin : g_last
            assign cell_d[k] = tail_rec;
        end else begin : g_mid
            assign cell_d[k] = cell_q[k + 1];
        end

        // entries a sync finish would drop, sampled while the ring is at rest
        assign drop_mask[k] = cell_q[k].valid && !cell_q[k].mark;

        pdwt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (shift),
            .i_rec   (cell_d[k]),
            .o_rec   (cell_q[k])
        );
    end

    pdwt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_head      (cell_q[0]),
        .i_drop_mask (drop_mask),
        .o_tail      (tail_rec),
        .o_shift     (shift)
    );

endmodule

`default_nettype wire

@@ hw/rtl/pdwt_cell.sv @@
// One record cell of the whitelist ring; loads the record at its input on shift.
// Depends on pdwt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdwt_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_shift,
    input  wire pdwt_pkg::t_rec i_rec,
    output pdwt_pkg::t_rec     o_rec
);

    pdwt_pkg::t_rec r_rec;

    // only valid and mark are reset; the record fields are read under valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec.valid <= 1'b0;
            r_rec.mark  <= 1'b0;
        end else if (i_shift) begin
            r_rec <= i_rec;
        end
    end

    assign o_rec = r_rec;

endmodule

`default_nettype wire

@@ hw/rtl/pdwt_ctrl.sv @@
// Walk controller: drives the output register; works on the ring head
// record, one per cycle unless stalled. Needs pdwt_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module pdwt_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire pdwt_pkg::t_in              i_in,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output pdwt_pkg::t_out                  o_out,
    input  wire pdwt_pkg::t_rec             i_head,
    input  wire logic [pdwt_pkg::ENTRIES-1:0] i_drop_mask,
    output pdwt_pkg::t_rec                  o_tail,
    output logic                            o_shift
);

    localparam logic [pdwt_pkg::IDX_W-1:0] LAST_STEP =
        pdwt_pkg::IDX_W'(pdwt_pkg::ENTRIES - 1);

    pdwt_pkg::t_state r_state, n_state;
    logic [pdwt_pkg::IDX_W-1:0] r_step;
    logic [2:0]  r_kind;
    logic [3:0]  r_len;
    logic [63:0] r_id;
    logic [47:0] r_mac;
    logic [63:0] r_key_hi, r_key_lo;
    logic [15:0] r_dev_in;
    logic        r_done, n_done;
    logic [15:0] r_dev, n_dev;
    logic [63:0] r_khi, n_khi, r_klo, n_klo;
    logic [pdwt_pkg::ENTRIES-1:0] r_mask;
    logic        r_out_valid;
    pdwt_pkg::t_out r_out;

    logic        in_fire, out_free, match, stall, emit, later_any;
    logic [3:0]  in_len;
    pdwt_pkg::t_out emit_rec;
    pdwt_pkg::t_rec new_rec;

    assign out_free = !r_out_valid || i_out_ready;
    assign in_fire  = i_in_valid && o_in_ready;
    assign in_len   = (i_in.slot_len > 4'(pdwt_pkg::SLOT_ID_BYTES)) ?
                      4'(pdwt_pkg::SLOT_ID_BYTES) : i_in.slot_len;
    assign match    = i_head.valid && i_head.slot_len == r_len && i_head.slot_id == r_id;

    // any unmarked valid entry after the current step
    always_comb begin
        later_any = 1'b0;
        for (int j = 0; j < pdwt_pkg::ENTRIES; j++) begin
            if (pdwt_pkg::IDX_W'(j) > r_step && r_mask[j]) later_any = 1'b1;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_done   = r_done;
        n_dev    = r_dev;
        n_khi    = r_khi;
        n_klo    = r_klo;
        new_rec  = i_head;
        emit     = 1'b0;
        emit_rec = '0;
        stall    = 1'b0;
        o_in_ready = (r_state == pdwt_pkg::S_IDLE);

        case (r_state)
            pdwt_pkg::S_IDLE: begin
                if (i_in_valid) n_state = pdwt_pkg::S_WALK;
            end
            pdwt_pkg::S_WALK: begin
                case (r_kind)
                    pdwt_pkg::K_ADD: begin
                        if (!r_done && !i_head.valid) begin
                            new_rec.valid    = 1'b1;
                            new_rec.mark     = 1'b0;
                            new_rec.slot_len = r_len;
                            new_rec.slot_id  = r_id;
                            new_rec.mac      = r_mac;
                            new_rec.key_hi   = r_key_hi;
                            new_rec.key_lo   = r_key_lo;
                            new_rec.device   = r_dev_in;
                            n_done           = 1'b1;
                        end
                    end
                    pdwt_pkg::K_REMOVE: begin
                        if (!r_done && match) begin
                            new_rec.valid = 1'b0;
                            new_rec.mark  = 1'b0;
                            n_dev         = i_head.device;
                            n_done        = 1'b1;
                        end
                    end
                    pdwt_pkg::K_SYNC_MARK: begin
                        if (match) begin
                            new_rec.mark = 1'b1;
                            n_done       = 1'b1;
                        end
                    end
                    pdwt_pkg::K_SYNC_FIN: begin
                        if (!i_head.mark) begin
                            new_rec.valid = 1'b0;
                            if (i_head.valid) begin
                                emit                    = 1'b1;
                                emit_rec.status         = pdwt_pkg::ST_DONE;
                                emit_rec.bond_drop      = 1'b1;
                                emit_rec.dropped_device = i_head.device;
                                emit_rec.last           = !later_any;
                                stall                   = !out_free;
                            end
                        end
                        new_rec.mark = 1'b0;
                    end
                    pdwt_pkg::K_CLEAR: begin
                        new_rec.valid = 1'b0;
                        new_rec.mark  = 1'b0;
                    end
                    pdwt_pkg::K_LOOKUP: begin
                        if (!r_done && i_head.valid && i_head.mac == r_mac) begin
                            n_khi  = i_head.key_hi;
                            n_klo  = i_head.key_lo;
                            n_done = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (!stall && r_step == LAST_STEP) begin
                    n_state = (r_kind == pdwt_pkg::K_SYNC_FIN && r_mask != '0) ?
                              pdwt_pkg::S_IDLE : pdwt_pkg::S_FINAL;
                end
            end
            pdwt_pkg::S_FINAL: begin
                emit          = 1'b1;
                emit_rec.last = 1'b1;
                case (r_kind)
                    pdwt_pkg::K_ADD: begin
                        emit_rec.status = r_done ? pdwt_pkg::ST_DONE : pdwt_pkg::ST_FULL;
                    end
                    pdwt_pkg::K_REMOVE: begin
                        emit_rec.status         = r_done ? pdwt_pkg::ST_DONE
                                                         : pdwt_pkg::ST_NOMATCH;
                        emit_rec.bond_drop      = r_done;
                        emit_rec.dropped_device = r_done ? r_dev : 16'd0;
                    end
                    pdwt_pkg::K_SYNC_MARK: begin
                        emit_rec.status = r_done ? pdwt_pkg::ST_DONE : pdwt_pkg::ST_NOMATCH;
                    end
                    pdwt_pkg::K_SYNC_FIN, pdwt_pkg::K_CLEAR: begin
                        emit_rec.status = pdwt_pkg::ST_DONE;
                    end
                    pdwt_pkg::K_LOOKUP: begin
                        emit_rec.status       = r_done ? pdwt_pkg::ST_DONE
                                                       : pdwt_pkg::ST_NOMATCH;
                        emit_rec.found        = r_done;
                        emit_rec.found_key_hi = r_done ? r_khi : 64'd0;
                        emit_rec.found_key_lo = r_done ? r_klo : 64'd0;
                    end
                    default: begin
                        emit_rec.status = pdwt_pkg::ST_NOMATCH;
                    end
                endcase
                if (out_free) n_state = pdwt_pkg::S_IDLE;
            end
            default: begin
                n_state = pdwt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_shift = (r_state == pdwt_pkg::S_WALK) && !stall;
    assign o_tail  = new_rec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pdwt_pkg::S_IDLE;
            r_step      <= '0;
            r_done      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_fire) begin
                r_step <= '0;
                r_done <= 1'b0;
            end else if (o_shift) begin
                r_step <= (r_step == LAST_STEP) ? '0 : r_step + 1'b1;
                r_done <= n_done;
            end
            if (emit && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind   <= i_in.kind;
            r_len    <= in_len;
            r_id     <= i_in.slot_id & pdwt_pkg::slot_mask(in_len);
            r_mac    <= i_in.mac;
            r_key_hi <= i_in.key_hi;
            r_key_lo <= i_in.key_lo;
            r_dev_in <= i_in.device_id;
            r_mask   <= i_drop_mask;
        end
        if (o_shift) begin
            r_dev <= n_dev;
            r_khi <= n_khi;
            r_klo <= n_klo;
        end
        if (emit && out_free) r_out <= emit_rec;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `PDWT_ASSERT(a_walk_starts_at_zero,
        in_fire |=> (r_state == pdwt_pkg::S_WALK && r_step == '0),
        "walk did not start at step zero")
    `PDWT_ASSERT(a_walk_ends,
        (o_shift && r_step == LAST_STEP) |=> (r_state != pdwt_pkg::S_WALK),
        "walk ran past the last cell")
    `PDWT_ASSERT(a_sync_emit_is_drop,
        (emit && r_state == pdwt_pkg::S_WALK) |-> (r_kind == pdwt_pkg::K_SYNC_FIN &&
            emit_rec.bond_drop && i_head.valid && !i_head.mark),
        "walk result without a dropped entry")
    `PDWT_ASSERT(a_final_sync_empty,
        (r_state == pdwt_pkg::S_FINAL && r_kind == pdwt_pkg::K_SYNC_FIN) |-> (r_mask == '0),
        "extra closing result after sync drops")

endmodule

`default_nettype wire
